// ===== design/wsr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the whole-word search and replace block.
// Holds widths, character codes, register indexes, state and command types.
// Used by every module of the design but wsr_ram; depends on nothing.
package wsr_pkg;

    localparam int MAX_WORD  = 64;
    localparam int WORD_AW   = $clog2(MAX_WORD);
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 7;
    localparam int SUM_W     = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int TERM_MAX  = 8;
    localparam int CAP_LIMIT = 64;
    localparam int LEN_SAT   = 127;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WORD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_WORD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY       = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_WORD,
        ST_SPACE,
        ST_END
    } wsr_state_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_WORD,
        OUT_SPACE,
        OUT_END
    } wsr_out_kind_t;

    typedef struct packed {
        logic          take_char;
        logic          take_sep;
        wsr_out_kind_t load_kind;
    } wsr_cmd_t;

    typedef struct packed {
        logic is_sep;
        logic is_dot;
        logic word_fits;
        logic word_empty;
        logic last_idx;
        logic out_free;
        logic em_space;
        logic em_dot;
    } wsr_status_t;

endpackage

// ===== design/wsr_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input characters and the results.
// Depends on wsr_pkg for the character width.
interface wsr_in_if
    import wsr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface wsr_out_if
    import wsr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              has_char;
    logic              last;
    logic              overflow;

    modport source (output valid, output out_char, output has_char, output last,
                    output overflow, input ready);
    modport sink   (input valid, input out_char, input has_char, input last,
                    input overflow, output ready);
endinterface

// ===== design/wsr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module wsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/wsr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences character intake, word emission, space and end marker.
// Depends on wsr_pkg for the state, command and status types.
module wsr_ctrl
    import wsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  wsr_status_t status,
    output wsr_cmd_t    cmd
);

    wsr_state_t state_reg;
    wsr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.is_sep)
                begin
                    priority if (status.word_fits && !status.word_empty)
                        state_next = ST_PREP;
                    else if (status.word_fits && !status.is_dot)
                        state_next = ST_SPACE;
                    else if (status.is_dot)
                        state_next = ST_END;
                    else
                        state_next = ST_IDLE;
                end
            end
            // Waits for the first store read to come out of the registered RAM read port.
            ST_PREP:
            begin
                state_next = ST_WORD;
            end
            ST_WORD:
            begin
                if (status.out_free && status.last_idx)
                begin
                    priority if (status.em_space)
                        state_next = ST_SPACE;
                    else if (status.em_dot)
                        state_next = ST_END;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SPACE:
            begin
                if (status.out_free)
                begin
                    state_next = status.em_dot ? ST_END : ST_IDLE;
                end
            end
            ST_END:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.take_char = 1'b0;
        cmd.take_sep  = 1'b0;
        cmd.load_kind = OUT_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_char = in_valid && !status.is_sep;
                cmd.take_sep  = in_valid && status.is_sep;
            end
            ST_PREP:
            begin
                cmd.load_kind = OUT_NONE;
            end
            ST_WORD:
            begin
                cmd.load_kind = status.out_free ? OUT_WORD : OUT_NONE;
            end
            ST_SPACE:
            begin
                cmd.load_kind = status.out_free ? OUT_SPACE : OUT_NONE;
            end
            ST_END:
            begin
                cmd.load_kind = status.out_free ? OUT_END : OUT_NONE;
            end
            default:
            begin
                cmd.load_kind = OUT_NONE;
            end
        endcase
    end

endmodule

// ===== design/wsr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, word store, match tracking, output counting
// and the result register. Depends on wsr_pkg and wsr_ram.
module wsr_datapath
    import wsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [CHAR_W-1:0]    in_char,
    input  wsr_cmd_t             cmd,
    output wsr_status_t          status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAR_W-1:0]    out_char,
    output logic                 has_char,
    output logic                 last,
    output logic                 overflow
);

    // Configuration registers.
    logic [CFG_W-1:0] search_word_reg;
    logic [3:0]       search_length_reg;
    logic [CFG_W-1:0] replace_word_reg;
    logic [3:0]       replace_length_reg;
    logic [6:0]       capacity_reg;

    // Per-word and per-string state.
    logic [LEN_W-1:0] word_length_reg;
    logic             in_word_reg;
    logic             mismatch_reg;
    logic [LEN_W-1:0] output_count_reg;
    logic             overflow_seen_reg;

    // Latched decision for the word being emitted.
    logic             em_match_reg;
    logic [LEN_W-1:0] em_len_reg;
    logic             em_space_reg;
    logic             em_dot_reg;
    logic             em_ovf_reg;
    logic [WORD_AW-1:0] idx_reg;

    // Result register.
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              has_char_reg;
    logic              last_reg;
    logic              overflow_reg;

    logic [3:0]        slen;
    logic [3:0]        rlen;
    logic [6:0]        cap;
    logic              is_space;
    logic              is_dot;
    logic              match;
    logic [LEN_W-1:0]  wlen;
    logic [SUM_W-1:0]  need;
    logic              too_long;
    logic              fail;
    logic              fits;
    logic [CHAR_W-1:0] search_byte;
    logic              char_mismatch;
    logic [CHAR_W-1:0] replace_byte;
    logic [CHAR_W-1:0] store_q;
    logic              store_we;
    logic [WORD_AW-1:0] store_raddr;
    logic              out_free;

    assign slen = (search_length_reg > 4'(TERM_MAX)) ? 4'(TERM_MAX) : search_length_reg;
    assign rlen = (replace_length_reg > 4'(TERM_MAX)) ? 4'(TERM_MAX) : replace_length_reg;
    assign cap  = (capacity_reg > 7'(CAP_LIMIT)) ? 7'(CAP_LIMIT) : capacity_reg;

    assign is_space = (in_char == CHAR_SPACE);
    assign is_dot   = (in_char == CHAR_DOT);

    assign match = !mismatch_reg && (slen != 4'd0) && (word_length_reg == LEN_W'(slen));
    assign wlen  = match ? LEN_W'(rlen) : word_length_reg;
    assign need  = SUM_W'(output_count_reg) + SUM_W'(wlen) + SUM_W'(is_space) + SUM_W'(1);
    assign too_long = !match && (word_length_reg > LEN_W'(MAX_WORD));
    assign fail  = too_long || (need > SUM_W'(cap));
    assign fits  = in_word_reg && !overflow_seen_reg && !fail;

    // Only the first eight positions can match; later ones are caught by slen.
    assign search_byte   = search_word_reg[{word_length_reg[2:0], 3'b000} +: CHAR_W];
    assign char_mismatch = (word_length_reg >= LEN_W'(slen)) || (search_byte != in_char);
    assign replace_byte  = replace_word_reg[{idx_reg[2:0], 3'b000} +: CHAR_W];

    assign out_free = !out_valid_reg || out_ready;

    assign store_we    = cmd.take_char && (word_length_reg < LEN_W'(MAX_WORD));
    // Look one entry ahead while a character leaves, so the read keeps pace.
    assign store_raddr = (cmd.load_kind == OUT_WORD) ? idx_reg + WORD_AW'(1) : idx_reg;

    wsr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_WORD)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (word_length_reg[WORD_AW-1:0]),
        .wdata (in_char),
        .raddr (store_raddr),
        .rdata (store_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_word_reg    <= '0;
            search_length_reg  <= 4'd1;
            replace_word_reg   <= '0;
            replace_length_reg <= 4'd0;
            capacity_reg       <= 7'd50;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SEARCH_WORD:    search_word_reg    <= cfg_data;
                REG_SEARCH_LENGTH:  search_length_reg  <= cfg_data[3:0];
                REG_REPLACE_WORD:   replace_word_reg   <= cfg_data;
                REG_REPLACE_LENGTH: replace_length_reg <= cfg_data[3:0];
                REG_CAPACITY:       capacity_reg       <= cfg_data[6:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg   <= '0;
            in_word_reg       <= 1'b0;
            mismatch_reg      <= 1'b0;
            output_count_reg  <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (cmd.take_char)
        begin
            if (word_length_reg != LEN_W'(LEN_SAT))
            begin
                word_length_reg <= word_length_reg + LEN_W'(1);
            end
            in_word_reg <= 1'b1;
            if (char_mismatch)
            begin
                mismatch_reg <= 1'b1;
            end
        end
        else if (cmd.take_sep)
        begin
            word_length_reg <= '0;
            in_word_reg     <= 1'b0;
            mismatch_reg    <= 1'b0;
            if (is_dot)
            begin
                output_count_reg  <= '0;
                overflow_seen_reg <= 1'b0;
            end
            else if (fits)
            begin
                output_count_reg <= output_count_reg + wlen + LEN_W'(1);
            end
            else if (in_word_reg)
            begin
                overflow_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_sep)
        begin
            em_match_reg <= match;
            em_len_reg   <= wlen;
            em_space_reg <= fits && is_space;
            em_dot_reg   <= is_dot;
            em_ovf_reg   <= overflow_seen_reg || (in_word_reg && fail);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.take_sep)
        begin
            idx_reg <= '0;
        end
        else if (cmd.load_kind == OUT_WORD)
        begin
            idx_reg <= idx_reg + WORD_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_kind != OUT_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.load_kind)
            OUT_WORD:
            begin
                out_char_reg <= em_match_reg ? replace_byte : store_q;
                has_char_reg <= 1'b1;
                last_reg     <= 1'b0;
                overflow_reg <= 1'b0;
            end
            OUT_SPACE:
            begin
                out_char_reg <= CHAR_SPACE;
                has_char_reg <= 1'b1;
                last_reg     <= 1'b0;
                overflow_reg <= 1'b0;
            end
            OUT_END:
            begin
                out_char_reg <= '0;
                has_char_reg <= 1'b0;
                last_reg     <= 1'b1;
                overflow_reg <= em_ovf_reg;
            end
            OUT_NONE:
            begin
                out_char_reg <= out_char_reg;
            end
            default:
            begin
                out_char_reg <= out_char_reg;
            end
        endcase
    end

    assign status.is_sep     = is_space || is_dot;
    assign status.is_dot     = is_dot;
    assign status.word_fits  = fits;
    assign status.word_empty = (wlen == '0);
    assign status.last_idx   = ((LEN_W'(idx_reg) + LEN_W'(1)) == em_len_reg);
    assign status.out_free   = out_free;
    assign status.em_space   = em_space_reg;
    assign status.em_dot     = em_dot_reg;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign has_char  = has_char_reg;
    assign last      = last_reg;
    assign overflow  = overflow_reg;

endmodule

// ===== design/word_search_replace_top.sv =====
`timescale 1ns / 1ps
// Top level of the whole-word search and replace block.
// Depends on wsr_pkg, the channel interfaces, wsr_ctrl and wsr_datapath.
//
//   channel  | dir | payload                                | handshake
//   ---------+-----+----------------------------------------+--------------------
//   text     | in  | in_char                                | valid / ready
//   result   | out | out_char, has_char, last, overflow     | valid / ready
//   cfg      | in  | cfg_index, cfg_data                    | cfg_write, no wait
//
// A word character is taken while the controller is idle. A separator is taken
// likewise, and when the word is emitted, a prep state waits for the first
// word-store read, then each emitted character, space and end marker follows in
// turn; the word-store read port sets that pace. Input is not taken while a word
// is being emitted. Reset clears all control state; no clearing pass is needed.
// A stalled result holds the result register, and emission waits until it is transferred.
module word_search_replace_top
    import wsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    wsr_in_if.sink               text,
    wsr_out_if.source            result
);

    wsr_cmd_t    cmd;
    wsr_status_t status;

    wsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_ready (text.ready),
        .status   (status),
        .cmd      (cmd)
    );

    wsr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_char   (text.in_char),
        .cmd       (cmd),
        .status    (status),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_char  (result.out_char),
        .has_char  (result.has_char),
        .last      (result.last),
        .overflow  (result.overflow)
    );

endmodule

// ===== dv/word_search_replace_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for word_search_replace_top: drives strings through the text channel and
// checks every result against an in-bench prediction of the word rewrite.
// Depends on wsr_pkg, the channel interfaces and the block's RTL.
module word_search_replace_top_tb;
    import wsr_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              has_char;
        logic              last;
        logic              overflow;
    } char_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    wsr_in_if  text_ch ();
    wsr_out_if result_ch ();

    word_search_replace_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text      (text_ch),
        .result    (result_ch)
    );

    // Register copies as last written.
    logic [CFG_W-1:0]   search_term;
    logic [3:0]         search_len;
    logic [CFG_W-1:0]   replace_term;
    logic [3:0]         replace_len;
    logic [LEN_W-1:0]   capacity_cfg;

    // Rewrite state of the current string.
    logic [CHAR_W-1:0]  word_buf [MAX_WORD];
    logic [LEN_W-1:0]   word_len;
    logic               in_word;
    logic               word_miss;
    int                 out_count;
    logic               ovf_seen;

    logic [CHAR_W-1:0]  pending_chars [$];
    char_result_t       expected_results [$];
    int                 mismatches;
    int                 phase_items;

    int                 send_gap;
    int                 recv_stall;
    int                 long_hold;
    bit                 send_steady;
    bit                 recv_steady;
    bit                 long_hold_req;
    bit                 long_hold_done;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int term_len();
        return (search_len > 4'd8) ? 8 : int'(search_len);
    endfunction

    function automatic void expect_result(logic [CHAR_W-1:0] ch, logic has, logic lst,
                                          logic ovf);
        expected_results.push_back('{out_char: ch, has_char: has, last: lst, overflow: ovf});
    endfunction

    function automatic void clear_word();
        word_len  = '0;
        in_word   = 1'b0;
        word_miss = 1'b0;
    endfunction

    // Works out the results that one accepted character causes.
    task automatic predict_rewrite(input logic [CHAR_W-1:0] c);
        int  slen;
        int  rlen;
        int  wlen;
        int  sep;
        int  cap;
        int  i;
        bit  hit;
        slen = term_len();
        if (c == CHAR_SPACE || c == CHAR_DOT)
        begin
            if (in_word)
            begin
                hit  = !word_miss && slen != 0 && int'(word_len) == slen;
                rlen = (replace_len > 4'd8) ? 8 : int'(replace_len);
                wlen = hit ? rlen : int'(word_len);
                sep  = (c == CHAR_SPACE) ? 1 : 0;
                cap  = (capacity_cfg > CAP_LIMIT) ? CAP_LIMIT : int'(capacity_cfg);
                if (!ovf_seen)
                begin
                    if (!hit && word_len > MAX_WORD)
                        ovf_seen = 1'b1;
                    else if (out_count + wlen + sep + 1 > cap)
                        ovf_seen = 1'b1;
                    else
                    begin
                        for (i = 0; i < wlen; i++)
                            expect_result(hit ? replace_term[8*i +: 8]
                                              : word_buf[i[WORD_AW-1:0]],
                                          1'b1, 1'b0, 1'b0);
                        if (sep != 0)
                            expect_result(CHAR_SPACE, 1'b1, 1'b0, 1'b0);
                        out_count += wlen + sep;
                    end
                end
                clear_word();
            end
            if (c == CHAR_DOT)
            begin
                expect_result('0, 1'b0, 1'b1, ovf_seen);
                clear_word();
                out_count = 0;
                ovf_seen  = 1'b0;
            end
        end
        else
        begin
            if (word_len < MAX_WORD)
                word_buf[word_len[WORD_AW-1:0]] = c;
            // Positions past the term length can never match.
            if (int'(word_len) >= slen)
                word_miss = 1'b1;
            else if (search_term[8*word_len +: 8] != c)
                word_miss = 1'b1;
            if (word_len < LEN_SAT)
                word_len = word_len + 1'b1;
            in_word = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : text_source
        logic offer;
        if (!rst_n)
        begin
            text_ch.valid   <= 1'b0;
            text_ch.in_char <= '0;
            send_gap = 0;
        end
        else
        begin
            offer = text_ch.valid;
            if (text_ch.valid && text_ch.ready)
            begin
                predict_rewrite(text_ch.in_char);
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_chars.size() > 0)
                begin
                    text_ch.in_char <= pending_chars.pop_front();
                    offer = 1'b1;
                    send_gap = pick_gap(send_steady);
                end
            end
            text_ch.valid <= offer;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_sink
        char_result_t got;
        char_result_t want;
        logic         take;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_stall = 0;
            long_hold  = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.out_char = result_ch.out_char;
                got.has_char = result_ch.has_char;
                got.last     = result_ch.last;
                got.overflow = result_ch.overflow;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: %s%h %s%b %s%b %s%b",
                                 $time, "char=", got.out_char, "has=", got.has_char,
                                 "last=", got.last, "ovf=", got.overflow);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.out_char !== want.out_char || got.has_char !== want.has_char ||
                        got.last !== want.last || got.overflow !== want.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch (got/exp): %s%h/%h %s%b/%b %s%b/%b %s%b/%b",
                                     $time, "char=", got.out_char, want.out_char,
                                     "has=", got.has_char, want.has_char,
                                     "last=", got.last, want.last,
                                     "ovf=", got.overflow, want.overflow);
                    end
                end
            end
            // One long hold-off lets the block back up into its input.
            if (long_hold_req && !long_hold_done)
            begin
                long_hold      = 300;
                long_hold_done = 1'b1;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                take = 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                take = 1'b0;
            end
            else
            begin
                take = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall = pick_gap(recv_steady);
            end
            result_ch.ready <= take;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_registers(input logic [CFG_W-1:0] sw, input int sl,
                                 input logic [CFG_W-1:0] rw, input int rl, input int cap);
        write_reg(REG_SEARCH_WORD, sw);
        search_term = sw;
        write_reg(REG_SEARCH_LENGTH, CFG_W'(sl & 'hF));
        search_len = sl[3:0];
        write_reg(REG_REPLACE_WORD, rw);
        replace_term = rw;
        write_reg(REG_REPLACE_LENGTH, CFG_W'(rl & 'hF));
        replace_len = rl[3:0];
        write_reg(REG_CAPACITY, CFG_W'(cap & 'h7F));
        capacity_cfg = cap[LEN_W-1:0];
    endtask

    function automatic logic [CHAR_W-1:0] rand_word_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        while (c == CHAR_SPACE || c == CHAR_DOT)
            c = CHAR_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [CFG_W-1:0] rand_term();
        logic [CFG_W-1:0] t;
        int               i;
        case ($urandom_range(0, 5))
            0: t = '0;
            1: t = '1;
            2: t = {$urandom, $urandom};
            default:
                for (i = 0; i < 8; i++)
                    t[8*i +: 8] = rand_word_char();
        endcase
        return t;
    endfunction

    function automatic void queue_char(input logic [CHAR_W-1:0] c);
        pending_chars.push_back(c);
        phase_items++;
    endfunction

    function automatic void queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_char(s[i]);
    endfunction

    // A well-formed string most of the time: words, single or double spaces, a final dot.
    task automatic queue_sentence();
        int nwords;
        int w;
        int i;
        int kind;
        int len;
        int slen;
        slen = term_len();
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
                queue_char(CHAR_W'($urandom_range(0, 255)));
            queue_char(CHAR_DOT);
            return;
        end
        if ($urandom_range(0, 4) == 0)
            queue_char(CHAR_SPACE);
        nwords = $urandom_range(1, 3);
        for (w = 0; w < nwords; w++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40 && slen > 0)
            begin
                for (i = 0; i < slen; i++)
                    queue_char(search_term[8*i +: 8]);
            end
            else if (kind < 55 && slen > 0)
            begin
                // Near miss: one character short of the term, or one too many.
                len = (slen > 1 && $urandom_range(0, 1) == 0) ? slen - 1 : slen + 1;
                for (i = 0; i < len; i++)
                    queue_char((i < slen) ? search_term[8*i +: 8] : rand_word_char());
            end
            else
            begin
                len = (kind < 95) ? $urandom_range(1, 8) : $urandom_range(9, 70);
                for (i = 0; i < len; i++)
                    queue_char(rand_word_char());
            end
            if (w == nwords - 1)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_char(CHAR_SPACE);
                queue_char(CHAR_DOT);
            end
            else
            begin
                queue_char(CHAR_SPACE);
                if ($urandom_range(0, 4) == 0)
                    queue_char(CHAR_SPACE);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || text_ch.valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        // A separator that emits nothing may still be in flight.
        repeat (20) @(negedge clk);
    endtask

    task automatic run_phase(input bit pressure);
        send_steady   = pressure || ($urandom_range(0, 3) == 0);
        recv_steady   = ($urandom_range(0, 3) == 0);
        long_hold_req = pressure;
        phase_items   = 0;
        while (phase_items < 4)
            queue_sentence();
        wait_drained();
    endtask

    task automatic random_setup();
        int pick;
        int sl;
        int rl;
        int cap;
        pick = $urandom_range(0, 9);
        sl   = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
        rl   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        pick = $urandom_range(0, 9);
        cap  = (pick < 5) ? 64 : (pick < 7) ? $urandom_range(2, 20) :
               (pick < 9) ? $urandom_range(21, 63) : $urandom_range(65, 127);
        set_registers(rand_term(), sl, rand_term(), rl, cap);
    endtask

    initial
    begin : stimulus
        int i;
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        text_ch.valid   = 1'b0;
        text_ch.in_char = '0;
        result_ch.ready = 1'b0;
        search_term     = '0;
        search_len      = 4'd1;
        replace_term    = '0;
        replace_len     = 4'd0;
        capacity_cfg    = 7'd50;
        clear_word();
        out_count       = 0;
        ovf_seen        = 1'b0;
        mismatches      = 0;
        send_steady     = 1'b0;
        recv_steady     = 1'b0;
        long_hold_req   = 1'b0;
        long_hold_done  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers as reset: the one-character term is a zero byte, replaced by nothing.
        queue_char(8'h00);
        queue_char(CHAR_SPACE);
        queue_char(8'h00);
        queue_char(8'h00);
        queue_char(CHAR_SPACE);
        queue_char(8'hFF);
        queue_char(CHAR_DOT);
        queue_char(CHAR_DOT);
        queue_char(CHAR_SPACE);
        queue_char(CHAR_DOT);
        wait_drained();

        set_registers(64'h0000_0000_0074_6163, 3, 64'h0000_0065_7372_6F68, 5, 64);
        queue_text("cat cats ca  cat.");
        wait_drained();

        // Largest lengths, capacity above the limit.
        set_registers('1, 8, '0, 8, 127);
        run_phase(1'b0);
        // Search length zero never matches; capacity zero overflows every word.
        set_registers(rand_term(), 0, rand_term(), 15, 0);
        run_phase(1'b0);
        set_registers(rand_term(), 15, rand_term(), 0, 1);
        run_phase(1'b0);

        // A word longer than the word store.
        set_registers(rand_term(), 1, rand_term(), 8, 12);
        for (i = 0; i < 66; i++)
            queue_char(rand_word_char());
        queue_char(CHAR_DOT);
        wait_drained();

        set_registers(rand_term(), $urandom_range(2, 6), rand_term(), $urandom_range(3, 8), 64);
        run_phase(1'b1);

        repeat (2)
        begin
            random_setup();
            run_phase(1'b0);
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(2_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== word_search_replace_top.f =====
design/wsr_pkg.sv
design/wsr_stream_if.sv
design/wsr_ram.sv
design/wsr_ctrl.sv
design/wsr_datapath.sv
design/word_search_replace_top.sv
dv/word_search_replace_top_tb.sv
